### design/bdp_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and fixed-point helpers for the lens distortion projector.
// No dependencies; every other file uses this package.
package bdp_pkg;

  localparam int unsigned CfgIdxW = 4;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_DEPTH = 2'd1,
    STAT_OVF   = 2'd2
  } bdp_status_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_K1   = 4'd0,
    REG_K2   = 4'd1,
    REG_K3   = 4'd2,
    REG_TAN  = 4'd3,
    REG_FX   = 4'd4,
    REG_FY   = 4'd5,
    REG_SKEW = 4'd6,
    REG_PP   = 4'd7
  } bdp_reg_e;

  typedef struct packed {
    logic signed [31:0] k1;
    logic signed [31:0] k2;
    logic signed [31:0] k3;
    logic signed [31:0] p1;
    logic signed [31:0] p2;
    logic [30:0]        fx;
    logic [30:0]        fy;
    logic signed [31:0] skew;
    logic signed [31:0] cx;
    logic signed [31:0] cy;
  } bdp_cfg_t;

  // normalized coordinates leaving the divider
  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic               ovf;
    logic               zb;
  } bdp_norm_t;

  // projected pixel leaving the distortion pipe
  typedef struct packed {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic               ovf;
    logic               zb;
  } bdp_pix_t;

  typedef struct packed {
    logic               ovf;
    logic signed [31:0] val;
  } bdp_sat_t;

  // clamp a wide sum to 32 bits and flag the clamp
  function automatic bdp_sat_t sat32(input logic signed [47:0] v);
    bdp_sat_t r;
    if (v > 48'sh00007FFFFFFF) begin
      r.ovf = 1'b1;
      r.val = 32'h7FFFFFFF;
    end else if (v < 48'shFFFF80000000) begin
      r.ovf = 1'b1;
      r.val = 32'h80000000;
    end else begin
      r.ovf = 1'b0;
      r.val = v[31:0];
    end
    return r;
  endfunction

  function automatic logic signed [47:0] sx(input logic signed [31:0] v);
    return 48'(v);
  endfunction

  // floor of a product shifted down by 28
  function automatic logic signed [47:0] fl28(input logic signed [63:0] p);
    return 48'($signed(p[63:28]));
  endfunction

  // floor of a product shifted down by 24
  function automatic logic signed [47:0] fl24(input logic signed [63:0] p);
    return 48'($signed(p[63:24]));
  endfunction

endpackage

### design/bdp_ifs.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces: ray in, pixel out, register write.
// Depends on bdp_pkg for the register index width.
interface bdp_ray_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] ray_x;
  logic signed [31:0] ray_y;
  logic signed [31:0] ray_z;
  modport source (output valid, ray_x, ray_y, ray_z, input ready);
  modport sink   (input valid, ray_x, ray_y, ray_z, output ready);
endinterface

interface bdp_pix_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pixel_x;
  logic signed [31:0] pixel_y;
  logic [1:0]         status;
  modport source (output valid, pixel_x, pixel_y, status, input ready);
  modport sink   (input valid, pixel_x, pixel_y, status, output ready);
endinterface

interface bdp_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [bdp_pkg::CfgIdxW-1:0]    index;
  logic [63:0]                    data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### design/brown_distort_project_core.sv
`timescale 1ns / 1ps
// Top level of the ray to pixel projector with lens distortion.
// Depends on bdp_pkg, bdp_ifs, bdp_div and bdp_dist.
//
// Usage:
//   ray_i  takes one ray word (ray_x, ray_y, ray_z, Q16.16) per valid/ready handshake.
//   pix_o  gives one pixel word (pixel_x, pixel_y Q16.16, status) per ray, in order.
//   cfg_i  writes one register per handshake (index 0..7, 64-bit data); it is
//          always ready, and writes should be made while no ray is in flight.
// Pipeline: the pipelined divider (one quotient bit per stage), then the
//   distortion and projection multiplier stages, then the output register.
// Throughput: one ray per clock while pix_o is taken.
// Stall: the whole pipe holds when the output word waits and pix_o.ready is
//   low; ray_i.ready drops in the same cycle, so nothing is lost or repeated.
// Reset: clears all valid bits and sets the configuration registers to zero.
// Status: ok, depth at or below zero (pixel fields zero), or overflow with
//   saturated fields.
module brown_distort_project_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  bdp_ray_if.sink       ray_i,
  bdp_cfg_if.sink       cfg_i,
  bdp_pix_if.source     pix_o
);
  import bdp_pkg::*;

  bdp_cfg_t  cfg_q;
  logic      en;
  logic      div_v, dist_v;
  bdp_norm_t norm;
  bdp_pix_t  pix;
  logic               out_v_q;
  logic signed [31:0] out_px_q, out_py_q;
  bdp_status_e        out_st_q;

  assign en          = !out_v_q || pix_o.ready;
  assign ray_i.ready = en;
  assign cfg_i.ready = 1'b1;

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        REG_K1:   cfg_q.k1 <= cfg_i.data[31:0];
        REG_K2:   cfg_q.k2 <= cfg_i.data[31:0];
        REG_K3:   cfg_q.k3 <= cfg_i.data[31:0];
        REG_TAN: begin
          cfg_q.p1 <= cfg_i.data[31:0];
          cfg_q.p2 <= cfg_i.data[63:32];
        end
        REG_FX:   cfg_q.fx <= cfg_i.data[30:0];
        REG_FY:   cfg_q.fy <= cfg_i.data[30:0];
        REG_SKEW: cfg_q.skew <= cfg_i.data[31:0];
        REG_PP: begin
          cfg_q.cx <= cfg_i.data[31:0];
          cfg_q.cy <= cfg_i.data[63:32];
        end
        default: ;
      endcase
    end
  end

  bdp_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (ray_i.valid),
    .rx_i    (ray_i.ray_x),
    .ry_i    (ray_i.ray_y),
    .rz_i    (ray_i.ray_z),
    .valid_o (div_v),
    .norm_o  (norm)
  );

  bdp_dist u_dist (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (div_v),
    .norm_i  (norm),
    .cfg_i   (cfg_q),
    .valid_o (dist_v),
    .pix_o   (pix)
  );

  // output word register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (en) begin
      out_v_q <= dist_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (pix.zb) begin
        out_px_q <= '0;
        out_py_q <= '0;
        out_st_q <= STAT_DEPTH;
      end else begin
        out_px_q <= pix.px;
        out_py_q <= pix.py;
        out_st_q <= pix.ovf ? STAT_OVF : STAT_OK;
      end
    end
  end

  assign pix_o.valid   = out_v_q;
  assign pix_o.pixel_x = out_px_q;
  assign pix_o.pixel_y = out_py_q;
  assign pix_o.status  = out_st_q;

endmodule

### design/bdp_div.sv
`timescale 1ns / 1ps
// Pipelined restoring divider: x = floor(rx*2^28/rz), y likewise, one bit per stage.
// Depends on bdp_pkg.
module bdp_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  logic signed [31:0] rx_i,
  input  logic signed [31:0] ry_i,
  input  logic signed [31:0] rz_i,
  output logic               valid_o,
  output bdp_pkg::bdp_norm_t norm_o
);
  import bdp_pkg::*;

  localparam int unsigned Steps = 32;

  typedef struct packed {
    logic [30:0] rem_x;
    logic [30:0] rem_y;
    logic [31:0] q_x;
    logic [31:0] q_y;
    logic [3:0]  nib_x;
    logic [3:0]  nib_y;
    logic [30:0] den;
    logic        sgn_x;
    logic        sgn_y;
    logic        pre_x;
    logic        pre_y;
    logic        zb;
  } dstage_t;

  // one restoring step: {quotient bit, new remainder}
  function automatic logic [31:0] step_fn(input logic [30:0] rem, input logic nb,
                                          input logic [30:0] den);
    logic [31:0] sh;
    logic [31:0] diff;
    sh   = {rem, nb};
    diff = sh - {1'b0, den};
    if (sh >= {1'b0, den}) return {1'b1, diff[30:0]};
    return {1'b0, sh[30:0]};
  endfunction

  // sign, range clamp and final rounding toward minus infinity
  function automatic bdp_sat_t fin_fn(input logic sgn, input logic pre,
                                      input logic [31:0] q, input logic remnz);
    bdp_sat_t    r;
    logic [32:0] m;
    logic [32:0] n;
    m = {1'b0, q} + 33'(remnz);
    n = ~m + 33'd1;
    if (!sgn) begin
      r.ovf = pre || q[31];
      r.val = r.ovf ? 32'h7FFFFFFF : q;
    end else begin
      r.ovf = pre || (m > 33'h080000000);
      r.val = r.ovf ? 32'h80000000 : n[31:0];
    end
    return r;
  endfunction

  dstage_t      st_q [Steps+1];
  logic [Steps:0] v_q;
  logic [31:0]  mag_x, mag_y;
  dstage_t      st0_d;
  bdp_sat_t     fx_d, fy_d;
  bdp_norm_t    norm_q;
  logic         vout_q;

  // set up magnitudes and the early range check
  always_comb begin
    mag_x = rx_i[31] ? 32'(-rx_i) : 32'(rx_i);
    mag_y = ry_i[31] ? 32'(-ry_i) : 32'(ry_i);
    st0_d.den   = rz_i[30:0];
    st0_d.zb    = rz_i[31] || (rz_i == 32'sd0);
    st0_d.rem_x = 31'(mag_x[31:4]);
    st0_d.rem_y = 31'(mag_y[31:4]);
    st0_d.pre_x = 31'(mag_x[31:4]) >= rz_i[30:0];
    st0_d.pre_y = 31'(mag_y[31:4]) >= rz_i[30:0];
    st0_d.nib_x = mag_x[3:0];
    st0_d.nib_y = mag_y[3:0];
    st0_d.sgn_x = rx_i[31];
    st0_d.sgn_y = ry_i[31];
    st0_d.q_x   = '0;
    st0_d.q_y   = '0;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) st_q[0] <= st0_d;
  end

  // one quotient bit per stage
  for (genvar k = 0; k < Steps; k++) begin : g_step
    logic [31:0] sx_w, sy_w;
    dstage_t     nx_w;
    assign sx_w = step_fn(st_q[k].rem_x, st_q[k].nib_x[3], st_q[k].den);
    assign sy_w = step_fn(st_q[k].rem_y, st_q[k].nib_y[3], st_q[k].den);
    // build the next stage word
    always_comb begin
      nx_w       = st_q[k];
      nx_w.rem_x = sx_w[30:0];
      nx_w.rem_y = sy_w[30:0];
      nx_w.q_x   = {st_q[k].q_x[30:0], sx_w[31]};
      nx_w.q_y   = {st_q[k].q_y[30:0], sy_w[31]};
      nx_w.nib_x = {st_q[k].nib_x[2:0], 1'b0};
      nx_w.nib_y = {st_q[k].nib_y[2:0], 1'b0};
    end
    always_ff @(posedge clk_i) begin
      if (en_i) st_q[k+1] <= nx_w;
    end
  end

  assign fx_d = fin_fn(st_q[Steps].sgn_x, st_q[Steps].pre_x, st_q[Steps].q_x,
                       st_q[Steps].rem_x != '0);
  assign fy_d = fin_fn(st_q[Steps].sgn_y, st_q[Steps].pre_y, st_q[Steps].q_y,
                       st_q[Steps].rem_y != '0);

  // register the finished quotients
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      norm_q.x   <= fx_d.val;
      norm_q.y   <= fy_d.val;
      norm_q.ovf <= fx_d.ovf | fy_d.ovf;
      norm_q.zb  <= st_q[Steps].zb;
    end
  end

  // advance valid bits with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q    <= '0;
      vout_q <= 1'b0;
    end else if (en_i) begin
      v_q    <= {v_q[Steps-1:0], valid_i};
      vout_q <= v_q[Steps];
    end
  end

  assign valid_o = vout_q;
  assign norm_o  = norm_q;

endmodule

### design/bdp_dist.sv
`timescale 1ns / 1ps
// Brown-Conrady distortion and pinhole projection in a chain of multiplier stages.
// Depends on bdp_pkg; result leaves combinationally from the last stage.
module bdp_dist (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  bdp_pkg::bdp_norm_t norm_i,
  input  bdp_pkg::bdp_cfg_t  cfg_i,
  output logic               valid_o,
  output bdp_pkg::bdp_pix_t  pix_o
);
  import bdp_pkg::*;

  localparam int unsigned Stages = 11;

  logic [Stages-1:0] v_q;
  logic [Stages-1:0] ovf_q;
  logic [Stages-1:0] zb_q;

  logic signed [63:0] a_x2p_q, a_y2p_q, a_xyp_q;
  logic signed [31:0] a_x_q, a_y_q;
  logic signed [31:0] b_x2_q, b_y2_q, b_xy_q, b_r2_q, b_x_q, b_y_q;
  logic signed [63:0] c_r4p_q, c_k1p_q;
  logic signed [31:0] c_ux_q, c_uy_q, c_x_q, c_y_q, c_r2_q, c_xy_q;
  logic signed [31:0] d_r4_q, d_r2_q, d_x_q, d_y_q;
  logic signed [47:0] d_t1_q;
  logic signed [63:0] d_p1xy_q, d_p2ux_q, d_p1uy_q, d_p2xy_q;
  logic signed [63:0] e_r6p_q, e_k2p_q;
  logic signed [47:0] e_t1_q, e_tx_q, e_ty_q;
  logic signed [31:0] e_x_q, e_y_q;
  logic signed [31:0] f_r6_q, f_x_q, f_y_q;
  logic signed [47:0] f_t1_q, f_t2_q, f_tx_q, f_ty_q;
  logic signed [63:0] g_k3p_q;
  logic signed [47:0] g_t1_q, g_t2_q, g_tx_q, g_ty_q;
  logic signed [31:0] g_x_q, g_y_q;
  logic signed [31:0] h_rad_q, h_x_q, h_y_q;
  logic signed [47:0] h_tx_q, h_ty_q;
  logic signed [63:0] i_xrp_q, i_yrp_q;
  logic signed [47:0] i_tx_q, i_ty_q;
  logic signed [31:0] j_xd_q, j_yd_q;
  logic signed [63:0] k_fxp_q, k_skp_q, k_fyp_q;

  bdp_sat_t x2_d, y2_d, xy_d, r2_d, ux_d, uy_d, r4_d, r6_d, rad_d, xd_d, yd_d, px_d, py_d;
  logic [Stages-1:0] ovf_d;

  // rounding, clamping and sums between the multiplier stages
  always_comb begin
    x2_d  = sat32(fl28(a_x2p_q));
    y2_d  = sat32(fl28(a_y2p_q));
    xy_d  = sat32(fl28(a_xyp_q));
    r2_d  = sat32(sx(x2_d.val) + sx(y2_d.val));
    ux_d  = sat32(sx(b_r2_q) + sx(b_x2_q) + sx(b_x2_q));
    uy_d  = sat32(sx(b_r2_q) + sx(b_y2_q) + sx(b_y2_q));
    r4_d  = sat32(fl28(c_r4p_q));
    r6_d  = sat32(fl28(e_r6p_q));
    rad_d = sat32(48'sd268435456 + g_t1_q + g_t2_q + fl24(g_k3p_q));
    xd_d  = sat32(fl28(i_xrp_q) + i_tx_q);
    yd_d  = sat32(fl28(i_yrp_q) + i_ty_q);
    px_d  = sat32(fl28(k_fxp_q) + fl28(k_skp_q) + sx(cfg_i.cx));
    py_d  = sat32(fl28(k_fyp_q) + sx(cfg_i.cy));

    ovf_d[0]  = norm_i.ovf;
    ovf_d[1]  = ovf_q[0] | x2_d.ovf | y2_d.ovf | xy_d.ovf | r2_d.ovf;
    ovf_d[2]  = ovf_q[1] | ux_d.ovf | uy_d.ovf;
    ovf_d[3]  = ovf_q[2] | r4_d.ovf;
    ovf_d[4]  = ovf_q[3];
    ovf_d[5]  = ovf_q[4] | r6_d.ovf;
    ovf_d[6]  = ovf_q[5];
    ovf_d[7]  = ovf_q[6] | rad_d.ovf;
    ovf_d[8]  = ovf_q[7];
    ovf_d[9]  = ovf_q[8] | xd_d.ovf | yd_d.ovf;
    ovf_d[10] = ovf_q[9];
  end

  // datapath stages
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      // square terms
      a_x2p_q <= norm_i.x * norm_i.x;
      a_y2p_q <= norm_i.y * norm_i.y;
      a_xyp_q <= norm_i.x * norm_i.y;
      a_x_q   <= norm_i.x;
      a_y_q   <= norm_i.y;
      // radius squared
      b_x2_q <= x2_d.val;
      b_y2_q <= y2_d.val;
      b_xy_q <= xy_d.val;
      b_r2_q <= r2_d.val;
      b_x_q  <= a_x_q;
      b_y_q  <= a_y_q;
      // r^4 and first radial term
      c_r4p_q <= b_r2_q * b_r2_q;
      c_k1p_q <= cfg_i.k1 * b_r2_q;
      c_ux_q  <= ux_d.val;
      c_uy_q  <= uy_d.val;
      c_x_q   <= b_x_q;
      c_y_q   <= b_y_q;
      c_r2_q  <= b_r2_q;
      c_xy_q  <= b_xy_q;
      // tangential products
      d_r4_q   <= r4_d.val;
      d_t1_q   <= fl24(c_k1p_q);
      d_p1xy_q <= cfg_i.p1 * c_xy_q;
      d_p2ux_q <= cfg_i.p2 * c_ux_q;
      d_p1uy_q <= cfg_i.p1 * c_uy_q;
      d_p2xy_q <= cfg_i.p2 * c_xy_q;
      d_r2_q   <= c_r2_q;
      d_x_q    <= c_x_q;
      d_y_q    <= c_y_q;
      // r^6 and second radial term
      e_r6p_q <= d_r4_q * d_r2_q;
      e_k2p_q <= cfg_i.k2 * d_r4_q;
      e_t1_q  <= d_t1_q;
      e_tx_q  <= fl24(d_p1xy_q) + fl24(d_p1xy_q) + fl24(d_p2ux_q);
      e_ty_q  <= fl24(d_p1uy_q) + fl24(d_p2xy_q) + fl24(d_p2xy_q);
      e_x_q   <= d_x_q;
      e_y_q   <= d_y_q;
      // clamp r^6
      f_r6_q <= r6_d.val;
      f_t1_q <= e_t1_q;
      f_t2_q <= fl24(e_k2p_q);
      f_tx_q <= e_tx_q;
      f_ty_q <= e_ty_q;
      f_x_q  <= e_x_q;
      f_y_q  <= e_y_q;
      // third radial term
      g_k3p_q <= cfg_i.k3 * f_r6_q;
      g_t1_q  <= f_t1_q;
      g_t2_q  <= f_t2_q;
      g_tx_q  <= f_tx_q;
      g_ty_q  <= f_ty_q;
      g_x_q   <= f_x_q;
      g_y_q   <= f_y_q;
      // radial factor
      h_rad_q <= rad_d.val;
      h_tx_q  <= g_tx_q;
      h_ty_q  <= g_ty_q;
      h_x_q   <= g_x_q;
      h_y_q   <= g_y_q;
      // scale by radial factor
      i_xrp_q <= h_x_q * h_rad_q;
      i_yrp_q <= h_y_q * h_rad_q;
      i_tx_q  <= h_tx_q;
      i_ty_q  <= h_ty_q;
      // distorted point
      j_xd_q <= xd_d.val;
      j_yd_q <= yd_d.val;
      // focal and skew products
      k_fxp_q <= $signed({1'b0, cfg_i.fx}) * j_xd_q;
      k_skp_q <= cfg_i.skew * j_yd_q;
      k_fyp_q <= $signed({1'b0, cfg_i.fy}) * j_yd_q;
      // carry flags
      ovf_q <= ovf_d;
      zb_q  <= {zb_q[Stages-2:0], norm_i.zb};
    end
  end

  // advance valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[Stages-2:0], valid_i};
    end
  end

  assign valid_o   = v_q[Stages-1];
  assign pix_o.px  = px_d.val;
  assign pix_o.py  = py_d.val;
  assign pix_o.ovf = ovf_q[Stages-1] | px_d.ovf | py_d.ovf;
  assign pix_o.zb  = zb_q[Stages-1];

endmodule

### tb/bdp_tb_ifs.sv
`timescale 1ns / 1ps
// Testbench-side word types for the ray and pixel channels.
// Depends on bdp_pkg; the channel interfaces come from the design's bdp_ifs.
package bdp_tb_pkg;
  import bdp_pkg::*;

  typedef struct packed {
    logic signed [31:0] rx;
    logic signed [31:0] ry;
    logic signed [31:0] rz;
  } ray_word_t;

  typedef struct packed {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic [1:0]         st;
  } pix_word_t;
endpackage

### tb/tb.sv
`timescale 1ns / 1ps
// Self-checking bench for brown_distort_project_core: rays in, pixels out.
// Depends on bdp_pkg, bdp_tb_pkg and the design's channel interfaces.
module tb;
  import bdp_pkg::*;
  import bdp_tb_pkg::*;

  localparam int Latency = 46;
  localparam longint CycleLimit = 400000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  bdp_ray_if ray_ch ();
  bdp_cfg_if cfg_ch ();
  bdp_pix_if pix_ch ();

  brown_distort_project_core dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .ray_i (ray_ch.sink),
    .cfg_i (cfg_ch.sink),
    .pix_o (pix_ch.source)
  );

  // model copy of the registers
  longint k1_m, k2_m, k3_m, p1_m, p2_m, fx_m, fy_m, skew_m, cx_m, cy_m;
  pix_word_t pending_pix[$];
  int  err_cnt = 0;
  int  ray_cnt = 0;
  int  pix_cnt = 0;
  int  ovf_cnt = 0;
  longint cyc = 0;
  int  send_idle = 0;
  int  recv_idle = 0;

  // generate clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // count cycles and stop a hung run
  always @(posedge clk_i) begin
    cyc <= cyc + 1;
    if (cyc > CycleLimit) begin
      $display("** brown_distort_project_core: FAILED **");
      $finish;
    end
  end

  function automatic longint sat_q(longint v, ref bit ovf);
    if (v > 64'sd2147483647) begin
      ovf = 1'b1;
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      ovf = 1'b1;
      return -64'sd2147483648;
    end
    return v;
  endfunction

  // arithmetic shift is floor for signed longint
  function automatic longint q28_mul(longint a, longint b);
    return (a * b) >>> 28;
  endfunction

  function automatic longint coef_mul(longint c, longint v);
    return (c * v) >>> 24;
  endfunction

  function automatic longint floor_div(longint num, longint den, ref bit ovf);
    longint n;
    longint q;
    n = num * 64'sd268435456;
    q = n / den;
    if (n % den < 0) q = q - 1;
    return sat_q(q, ovf);
  endfunction

  function automatic pix_word_t project_ray(ray_word_t r);
    pix_word_t o;
    bit ovf;
    longint x, y, x2, y2, xy, r2, r4, r6, rad, ux, uy, xd, yd, px, py;
    ovf = 1'b0;
    if (r.rz <= 0) begin
      o.px = '0;
      o.py = '0;
      o.st = STAT_DEPTH;
      return o;
    end
    x   = floor_div(longint'(r.rx), longint'(r.rz), ovf);
    y   = floor_div(longint'(r.ry), longint'(r.rz), ovf);
    x2  = sat_q(q28_mul(x, x), ovf);
    y2  = sat_q(q28_mul(y, y), ovf);
    xy  = sat_q(q28_mul(x, y), ovf);
    r2  = sat_q(x2 + y2, ovf);
    r4  = sat_q(q28_mul(r2, r2), ovf);
    r6  = sat_q(q28_mul(r4, r2), ovf);
    rad = sat_q(64'sd268435456 + coef_mul(k1_m, r2) + coef_mul(k2_m, r4)
                + coef_mul(k3_m, r6), ovf);
    ux  = sat_q(r2 + 2 * x2, ovf);
    uy  = sat_q(r2 + 2 * y2, ovf);
    xd  = sat_q(q28_mul(x, rad) + 2 * coef_mul(p1_m, xy) + coef_mul(p2_m, ux), ovf);
    yd  = sat_q(q28_mul(y, rad) + coef_mul(p1_m, uy) + 2 * coef_mul(p2_m, xy), ovf);
    px  = sat_q(((fx_m * xd) >>> 28) + ((skew_m * yd) >>> 28) + cx_m, ovf);
    py  = sat_q(((fy_m * yd) >>> 28) + cy_m, ovf);
    o.px = px[31:0];
    o.py = py[31:0];
    o.st = ovf ? STAT_OVF : STAT_OK;
    return o;
  endfunction

  // write one register, mirror it in the model
  task automatic write_reg(bdp_reg_e idx, logic [63:0] d);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= d;
    do @(posedge clk_i); while (!cfg_ch.ready);
    case (idx)
      REG_K1:   k1_m = longint'($signed(d[31:0]));
      REG_K2:   k2_m = longint'($signed(d[31:0]));
      REG_K3:   k3_m = longint'($signed(d[31:0]));
      REG_TAN: begin
        p1_m = longint'($signed(d[31:0]));
        p2_m = longint'($signed(d[63:32]));
      end
      REG_FX:   fx_m = longint'({33'd0, d[30:0]});
      REG_FY:   fy_m = longint'({33'd0, d[30:0]});
      REG_SKEW: skew_m = longint'($signed(d[31:0]));
      REG_PP: begin
        cx_m = longint'($signed(d[31:0]));
        cy_m = longint'($signed(d[63:32]));
      end
      default: ;
    endcase
  endtask

  task automatic write_all(logic [31:0] k1, logic [31:0] k2, logic [31:0] k3,
                           logic [63:0] tan, logic [31:0] fx, logic [31:0] fy,
                           logic [31:0] sk, logic [63:0] pp);
    write_reg(REG_K1, {32'd0, k1});
    write_reg(REG_K2, {32'd0, k2});
    write_reg(REG_K3, {32'd0, k3});
    write_reg(REG_TAN, tan);
    write_reg(REG_FX, {32'd0, fx});
    write_reg(REG_FY, {32'd0, fy});
    write_reg(REG_SKEW, {32'd0, sk});
    write_reg(REG_PP, pp);
    cfg_ch.valid <= 1'b0;
  endtask

  // send one ray word, honoring the sender idle rate
  task automatic send_ray(ray_word_t r);
    while ($urandom_range(99) < send_idle) begin
      ray_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    ray_ch.valid <= 1'b1;
    ray_ch.ray_x <= r.rx;
    ray_ch.ray_y <= r.ry;
    ray_ch.ray_z <= r.rz;
    do @(posedge clk_i); while (!ray_ch.ready);
    pending_pix.push_back(project_ray(r));
    ray_cnt++;
  endtask

  task automatic drain();
    ray_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_pix.size() != 0) @(posedge clk_i);
    repeat (Latency + 5) @(posedge clk_i);
  endtask

  // random ray: mostly realistic depth, some wild and non-positive ones
  function automatic ray_word_t rand_ray();
    ray_word_t r;
    int sel;
    sel = $urandom_range(9);
    if (sel < 6) begin
      r.rx = $signed($urandom_range(262144)) - 131072;
      r.ry = $signed($urandom_range(262144)) - 131072;
      r.rz = $urandom_range(32'h00100000, 32'h00008000);
    end else if (sel < 8) begin
      r.rx = $urandom;
      r.ry = $urandom;
      r.rz = $urandom;
    end else begin
      r.rx = $urandom;
      r.ry = $urandom;
      r.rz = -$signed($urandom_range(32'h7FFFFFFF));
    end
    return r;
  endfunction

  // receiver side: stall randomly, check each word
  always @(posedge clk_i) begin
    pix_word_t exp_w;
    if (!rst_ni) begin
      pix_ch.ready <= 1'b0;
    end else begin
      if (pix_ch.valid && pix_ch.ready) begin
        pix_cnt++;
        if (pending_pix.size() == 0) begin
          $error("pixel word with nothing expected");
          err_cnt++;
        end else begin
          exp_w = pending_pix.pop_front();
          if (exp_w.st == STAT_OVF) ovf_cnt++;
          if (pix_ch.pixel_x !== exp_w.px) begin
            $error("pixel_x expected %0d got %0d", exp_w.px, pix_ch.pixel_x);
            err_cnt++;
          end
          if (pix_ch.pixel_y !== exp_w.py) begin
            $error("pixel_y expected %0d got %0d", exp_w.py, pix_ch.pixel_y);
            err_cnt++;
          end
          if (pix_ch.status !== exp_w.st) begin
            $error("status expected %0d got %0d", exp_w.st, pix_ch.status);
            err_cnt++;
          end
        end
      end
      pix_ch.ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  task automatic test_reset_defaults();
    ray_word_t r;
    r = '{32'sh00010000, -32'sh00010000, 32'sh00010000};
    send_ray(r);
    r = '{0, 0, 0};
    send_ray(r);
    drain();
  endtask

  task automatic test_directed();
    ray_word_t r;
    write_all(32'hFF000000, 32'h00400000, 32'hFFF00000, {32'h00010000, 32'hFFFE0000},
              32'h01F40000, 32'h01F40000, 32'h00001000, {32'h00F00000, 32'h01400000});
    r = '{0, 0, 32'sh00010000};           send_ray(r);  // on axis
    r = '{32'sh00010000, 32'sh00008000, 32'sh00020000}; send_ray(r);
    r = '{0, 0, 0};                        send_ray(r);  // zero depth
    r = '{0, 0, 32'sh80000000};            send_ray(r);  // most negative depth
    r = '{0, 0, 32'sh00000001};            send_ray(r);  // smallest positive depth
    r = '{32'sh7FFFFFFF, 32'sh80000000, 32'sh00000001}; send_ray(r);  // divider clamp
    r = '{32'sh80000000, 32'sh7FFFFFFF, 32'sh7FFFFFFF}; send_ray(r);
    r = '{32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF}; send_ray(r);
    r = '{-32'sh00010000, -32'sh00010000, 32'sh00010000}; send_ray(r);
    r = '{32'sh00050000, 0, 32'sh00010000}; send_ray(r);  // r2 overflow
    drain();
    // extreme registers, all bits toggled
    write_all(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 64'hFFFFFFFF_FFFFFFFF,
              32'hFFFFFFFF, 32'hFFFFFFFF, 32'h80000000, 64'h7FFFFFFF_80000000);
    r = '{32'sh00004000, 32'shFFFFC000, 32'sh00010000}; send_ray(r);
    r = '{0, 0, 32'sh00010000};            send_ray(r);
    r = '{32'sh00010000, 32'sh00010000, 32'sh00010000}; send_ray(r);
    drain();
    write_all(32'h80000000, 32'h7FFFFFFF, 32'h80000000, 64'h80000000_7FFFFFFF,
              32'h00000000, 32'h7FFFFFFF, 32'h7FFFFFFF, 64'h80000000_7FFFFFFF);
    r = '{32'sh00002000, 32'sh00003000, 32'sh00010000}; send_ray(r);
    r = '{-32'sh00002000, 32'sh00001000, 32'sh00010000}; send_ray(r);
    drain();
  endtask

  task automatic test_random(int n_rays, int s_idle, int r_idle);
    send_idle = s_idle;
    recv_idle = r_idle;
    write_all($urandom_range(32'h02000000) - 32'h01000000,
              $urandom_range(32'h01000000) - 32'h00800000,
              $urandom_range(32'h00800000) - 32'h00400000,
              {$urandom_range(32'h00100000) - 32'h00080000,
               $urandom_range(32'h00100000) - 32'h00080000},
              $urandom_range(32'h04000000), $urandom_range(32'h04000000),
              $urandom_range(32'h00100000) - 32'h00080000,
              {$urandom, $urandom});
    for (int i = 0; i < n_rays; i++) begin
      send_ray(rand_ray());
      // hold off once until everything expected has arrived
      if (i == n_rays / 2) begin
        ray_ch.valid <= 1'b0;
        @(posedge clk_i);
        while (pending_pix.size() != 0) @(posedge clk_i);
      end
    end
    drain();
  endtask

  initial begin
    ray_ch.valid = 1'b0;
    ray_ch.ray_x = '0;
    ray_ch.ray_y = '0;
    ray_ch.ray_z = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data  = '0;
    pix_ch.ready = 1'b0;
    {k1_m, k2_m, k3_m, p1_m, p2_m, fx_m, fy_m, skew_m, cx_m, cy_m} = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    test_directed();
    test_random(280, 8, 49);
    test_random(280, 49, 8);
    test_random(270, 0, 0);
    $display("Sent %0d rays, checked %0d pixel words (%0d overflow) over %0d cycles.",
             ray_cnt, pix_cnt, ovf_cnt, cyc);
    if (err_cnt == 0 && pending_pix.size() == 0) begin
      $display("** brown_distort_project_core: PASSED **");
    end else begin
      $display("** brown_distort_project_core: FAILED **");
    end
    $finish;
  end
endmodule
